// ===== rtl/core/cartesian_tree_builder_unit_defines.svh =====
// Assertion macros used by cartesian_tree_builder_unit.sv.
// CTB_ASSERT checks the consequent in the same cycle; CTB_ASSERT_NEXT in the next one.
`ifndef CARTESIAN_TREE_BUILDER_UNIT_DEFINES_SVH
`define CARTESIAN_TREE_BUILDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CTB_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cartesian tree builder: assertion failed");
`define CTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cartesian tree builder: assertion failed");
`else
`define CTB_ASSERT(label, ante, cons)
`define CTB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/ctb_pkg.sv =====
package ctb_pkg;

    localparam int FUNC_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int NODE_IDX_W = 10;
    localparam int LINK_OUT_W = 11;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 56;

    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APP_CHK,
        ST_CLIMB,
        ST_WR_ENTRY,
        ST_WR_LINK,
        ST_Q_DATA,
        ST_DONE
    } ctb_state_t;

    typedef struct packed {
        logic key_we;
        logic par_we;
        logic left_we;
        logic right_we;
    } ctb_wr_t;

endpackage

// ===== rtl/core/ctb_store.sv =====
module ctb_store #(
    parameter int MAX_NODES = 1024,
    parameter int KEY_BITS  = 32
) (
    input  logic                           clk,
    input  ctb_pkg::ctb_wr_t               wr,
    input  logic [$clog2(MAX_NODES)-1:0]   ent_waddr,
    input  logic [$clog2(MAX_NODES)-1:0]   par_waddr,
    input  logic [$clog2(MAX_NODES)-1:0]   right_waddr,
    input  logic [KEY_BITS-1:0]            key_wdata,
    input  logic [$clog2(MAX_NODES):0]     par_wdata,
    input  logic [$clog2(MAX_NODES):0]     left_wdata,
    input  logic [$clog2(MAX_NODES):0]     right_wdata,
    input  logic [$clog2(MAX_NODES)-1:0]   rd_addr,
    output logic [KEY_BITS-1:0]            key_rdata,
    output logic [$clog2(MAX_NODES):0]     par_rdata,
    output logic [$clog2(MAX_NODES):0]     left_rdata,
    output logic [$clog2(MAX_NODES):0]     right_rdata
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int LINK_W = IDX_W + 1;

    logic [KEY_BITS-1:0] key_mem   [MAX_NODES];
    logic [LINK_W-1:0]   par_mem   [MAX_NODES];
    logic [LINK_W-1:0]   left_mem  [MAX_NODES];
    logic [LINK_W-1:0]   right_mem [MAX_NODES];

    logic [KEY_BITS-1:0] key_rd_reg;
    logic [LINK_W-1:0]   par_rd_reg;
    logic [LINK_W-1:0]   left_rd_reg;
    logic [LINK_W-1:0]   right_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[ent_waddr] <= key_wdata;
        end
        if (wr.par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        if (wr.left_we)
        begin
            left_mem[ent_waddr] <= left_wdata;
        end
        if (wr.right_we)
        begin
            right_mem[right_waddr] <= right_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        key_rd_reg   <= key_mem[rd_addr];
        par_rd_reg   <= par_mem[rd_addr];
        left_rd_reg  <= left_mem[rd_addr];
        right_rd_reg <= right_mem[rd_addr];
    end

    assign key_rdata   = key_rd_reg;
    assign par_rdata   = par_rd_reg;
    assign left_rdata  = left_rd_reg;
    assign right_rdata = right_rd_reg;

endmodule

// ===== rtl/core/cartesian_tree_builder_unit.sv =====
// Min-heap Cartesian tree builder. Items are worked one at a time; s_axis_tready is high
// only while the block is idle, but a finished result may still wait in the output
// register. Node keys and links live in single-port-read RAMs with a registered read, so
// each step up the right spine is a state of its own: an append passes ST_APP_CHK, one
// ST_CLIMB for each ancestor of the last node whose key is compared, ST_WR_ENTRY and
// ST_WR_LINK; a first append after a clear ST_WR_ENTRY, a stored node's query ST_Q_DATA,
// and any other item (an overflowed append, a query beyond the count, a clear or unused
// code) none; all then wait in ST_DONE while a previous result holds the output register.
// The stores need no clearing after reset, since only nodes below the count are ever read.
`include "cartesian_tree_builder_unit_defines.svh"

module cartesian_tree_builder_unit #(
    parameter int MAX_NODES = 1024,
    parameter int KEY_BITS  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // value [31:0], node_index [41:32], zero pad [47:42]
    input  logic [ctb_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // func [1:0]
    input  logic [ctb_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // parent [10:0], left_child [21:11], right_child [32:22], root [43:33],
    // node_count [54:44], overflow [55]
    output logic [ctb_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int LINK_W = IDX_W + 1;
    localparam int OUT_W  = ctb_pkg::LINK_OUT_W;
    localparam int NI_W   = ctb_pkg::NODE_IDX_W;
    localparam int VAL_W  = ctb_pkg::VALUE_W;
    localparam logic [LINK_W-1:0] NONE = '1;

    function automatic logic climbable(input logic [LINK_W-1:0] x, input logic [IDX_W-1:0] i);
        return !x[LINK_W-1] && (x < {1'b0, i});
    endfunction

    function automatic logic [OUT_W-1:0] link_out(input logic [LINK_W-1:0] x);
        logic [LINK_W+OUT_W-1:0] w;
        w = {{OUT_W{x[LINK_W-1]}}, x};
        return w[OUT_W-1:0];
    endfunction

    ctb_pkg::ctb_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [LINK_W-1:0]   root_reg, root_next;
    logic                out_valid_reg, out_valid_next;
    logic [ctb_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic signed [KEY_BITS-1:0] val_reg, val_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [LINK_W-1:0]   pp_reg, pp_next;
    logic                first_reg, first_next;
    logic                attach_reg, attach_next;
    logic [LINK_W-1:0]   res_par_reg, res_par_next;
    logic [LINK_W-1:0]   res_left_reg, res_left_next;
    logic [LINK_W-1:0]   res_right_reg, res_right_next;
    logic                res_ovf_reg, res_ovf_next;

    // input fields
    logic [ctb_pkg::FUNC_W-1:0] in_func;
    logic [VAL_W-1:0]           in_value;
    logic [VAL_W+KEY_BITS-1:0]  in_value_ext;
    logic [KEY_BITS-1:0]        in_key;
    logic [NI_W+CNT_W-1:0]      in_node_ext;
    logic [NI_W+CNT_W-1:0]      count_ext;
    logic                       in_node_ok;
    logic [OUT_W+CNT_W-1:0]     count_out_ext;

    // store port
    ctb_pkg::ctb_wr_t    wr;
    logic [IDX_W-1:0]    par_waddr, right_waddr, rd_addr;
    logic [LINK_W-1:0]   par_wdata, right_wdata;
    logic [KEY_BITS-1:0] key_rdata;
    logic [LINK_W-1:0]   par_rdata, left_rdata, right_rdata;

    assign in_func      = s_axis_tuser;
    assign in_value     = s_axis_tdata[VAL_W-1:0];
    assign in_value_ext = {{KEY_BITS{in_value[VAL_W-1]}}, in_value};
    assign in_key       = in_value_ext[KEY_BITS-1:0];
    assign in_node_ext  = {{CNT_W{1'b0}}, s_axis_tdata[VAL_W+NI_W-1:VAL_W]};
    assign count_ext    = {{NI_W{1'b0}}, count_reg};
    assign in_node_ok   = in_node_ext < count_ext;
    assign count_out_ext = {{OUT_W{1'b0}}, count_reg};

    // idle: look at the last node (append) or the queried node; later, follow the parent
    assign rd_addr = (state_reg != ctb_pkg::ST_IDLE) ? par_rdata[IDX_W-1:0] :
                     (in_func == ctb_pkg::FUNC_QUERY) ? in_node_ext[IDX_W-1:0] : last_reg;

    ctb_store #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS)
    ) u_store (
        .clk         (clk),
        .wr          (wr),
        .ent_waddr   (i_reg),
        .par_waddr   (par_waddr),
        .right_waddr (right_waddr),
        .key_wdata   (val_reg),
        .par_wdata   (par_wdata),
        .left_wdata  (res_left_reg),
        .right_wdata (right_wdata),
        .rd_addr     (rd_addr),
        .key_rdata   (key_rdata),
        .par_rdata   (par_rdata),
        .left_rdata  (left_rdata),
        .right_rdata (right_rdata)
    );

    assign s_axis_tready = (state_reg == ctb_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        val_next       = val_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        pp_next        = pp_reg;
        first_next     = first_reg;
        attach_next    = attach_reg;
        res_par_next   = res_par_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        res_ovf_next   = res_ovf_reg;
        wr             = '0;
        par_waddr      = i_reg;
        right_waddr    = i_reg;
        par_wdata      = res_par_reg;
        right_wdata    = NONE;

        case (state_reg)
            ctb_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_par_next   = NONE;
                    res_left_next  = NONE;
                    res_right_next = NONE;
                    res_ovf_next   = 1'b0;
                    state_next     = ctb_pkg::ST_DONE;
                    case (in_func)
                        ctb_pkg::FUNC_APPEND:
                        begin
                            val_next    = in_key;
                            i_next      = count_reg[IDX_W-1:0];
                            p_next      = last_reg;
                            first_next  = (count_reg == '0);
                            attach_next = 1'b0;
                            if (count_reg == CNT_W'(MAX_NODES))
                            begin
                                res_ovf_next = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ctb_pkg::ST_WR_ENTRY;
                            end
                            else
                            begin
                                state_next = ctb_pkg::ST_APP_CHK;
                            end
                        end
                        ctb_pkg::FUNC_QUERY:
                        begin
                            if (in_node_ok)
                            begin
                                state_next = ctb_pkg::ST_Q_DATA;
                            end
                        end
                        ctb_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                            last_next  = '0;
                            root_next  = NONE;
                        end
                        default:
                        begin
                            state_next = ctb_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ctb_pkg::ST_APP_CHK:
            begin
                state_next = ctb_pkg::ST_WR_ENTRY;
                if (val_reg < $signed(key_rdata))
                begin
                    pp_next       = par_rdata;
                    res_par_next  = par_rdata;
                    res_left_next = {1'b0, p_reg};
                    if (climbable(par_rdata, i_reg))
                    begin
                        state_next = ctb_pkg::ST_CLIMB;
                    end
                end
                else
                begin
                    attach_next   = 1'b1;
                    res_par_next  = {1'b0, p_reg};
                    res_left_next = NONE;
                end
            end
            ctb_pkg::ST_CLIMB:
            begin
                state_next = ctb_pkg::ST_WR_ENTRY;
                // move up one ancestor while the new key is still smaller
                if (val_reg < $signed(key_rdata))
                begin
                    p_next        = pp_reg[IDX_W-1:0];
                    pp_next       = par_rdata;
                    res_par_next  = par_rdata;
                    res_left_next = pp_reg;
                    if (climbable(par_rdata, i_reg))
                    begin
                        state_next = ctb_pkg::ST_CLIMB;
                    end
                end
            end
            ctb_pkg::ST_WR_ENTRY:
            begin
                wr.key_we   = 1'b1;
                wr.par_we   = 1'b1;
                wr.left_we  = 1'b1;
                wr.right_we = 1'b1;
                count_next  = count_reg + CNT_W'(1);
                last_next   = i_reg;
                if (first_reg)
                begin
                    root_next  = {1'b0, i_reg};
                    state_next = ctb_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ctb_pkg::ST_WR_LINK;
                end
            end
            ctb_pkg::ST_WR_LINK:
            begin
                par_waddr   = p_reg;
                par_wdata   = {1'b0, i_reg};
                right_wdata = {1'b0, i_reg};
                state_next  = ctb_pkg::ST_DONE;
                if (attach_reg)
                begin
                    wr.right_we = 1'b1;
                    right_waddr = p_reg;
                end
                else
                begin
                    // splice: the climbed-to node drops under the new one
                    wr.par_we   = 1'b1;
                    right_waddr = pp_reg[IDX_W-1:0];
                    if (climbable(pp_reg, i_reg))
                    begin
                        wr.right_we = 1'b1;
                    end
                    else
                    begin
                        root_next = {1'b0, i_reg};
                    end
                end
            end
            ctb_pkg::ST_Q_DATA:
            begin
                res_par_next   = par_rdata;
                res_left_next  = left_rdata;
                res_right_next = right_rdata;
                state_next     = ctb_pkg::ST_DONE;
            end
            ctb_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_ovf_reg,
                                      count_out_ext[OUT_W-1:0],
                                      link_out(root_reg),
                                      link_out(res_right_reg),
                                      link_out(res_left_reg),
                                      link_out(res_par_reg)};
                    state_next     = ctb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctb_pkg::ST_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            root_reg      <= NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        val_reg       <= val_next;
        i_reg         <= i_next;
        p_reg         <= p_next;
        pp_reg        <= pp_next;
        first_reg     <= first_next;
        attach_reg    <= attach_next;
        res_par_reg   <= res_par_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        res_ovf_reg   <= res_ovf_next;
    end

    `CTB_ASSERT(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_NODES))
    `CTB_ASSERT(a_root_empty, 1'b1, root_reg[LINK_W-1] == (count_reg == '0))
    `CTB_ASSERT(a_climb_link, state_reg == ctb_pkg::ST_CLIMB, climbable(pp_reg, i_reg))
    `CTB_ASSERT(a_ovf_no_links, m_axis_tvalid && m_axis_tdata[55], m_axis_tdata[32:0] == '1)
    `CTB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

// ===== bench/tb_cartesian_tree_builder_unit.sv =====
`timescale 1ns / 1ps

module tb_cartesian_tree_builder_unit;

    localparam int NODES = 1024;
    localparam logic [ctb_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam logic [ctb_pkg::LINK_OUT_W-1:0] NO_LINK = '1;
    localparam int NO_NODE = -1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 50;
    localparam int RANDOM_ITEMS = 100;

    // Laid out as m_axis_tdata: overflow in the top bit, parent in the lowest bits.
    typedef struct packed {
        logic                           ovf;
        logic [ctb_pkg::LINK_OUT_W-1:0] cnt;
        logic [ctb_pkg::LINK_OUT_W-1:0] root;
        logic [ctb_pkg::LINK_OUT_W-1:0] rch;
        logic [ctb_pkg::LINK_OUT_W-1:0] lch;
        logic [ctb_pkg::LINK_OUT_W-1:0] par;
    } tree_result_t;

    typedef enum {RX_FLOW, RX_CHOPPY, RX_STARVED} rx_mode_t;
    typedef enum {KEYS_ANY, KEYS_NARROW, KEYS_RISING, KEYS_FALLING} key_style_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ctb_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [ctb_pkg::FUNC_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ctb_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    // Shadow copy of the tree
    logic signed [ctb_pkg::VALUE_W-1:0] key_mem [NODES];
    int par_mem [NODES];
    int lch_mem [NODES];
    int rch_mem [NODES];
    int tail_node;
    int node_total;
    int root_node;

    tree_result_t pending_results[$];
    int mismatches = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int stall_left = 0;
    rx_mode_t stall_mode = RX_FLOW;
    key_style_t key_style = KEYS_ANY;
    int key_run = 0;
    logic signed [ctb_pkg::VALUE_W-1:0] last_key = '0;

    cartesian_tree_builder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic tree_result_t tree_step(input logic [ctb_pkg::FUNC_W-1:0] op,
                                               input logic signed [ctb_pkg::VALUE_W-1:0] key,
                                               input int idx);
        tree_result_t r;
        int i;
        int p;
        r.par = NO_LINK;
        r.lch = NO_LINK;
        r.rch = NO_LINK;
        r.ovf = 1'b0;
        case (op)
            ctb_pkg::FUNC_APPEND:
            begin
                if (node_total >= NODES)
                    r.ovf = 1'b1;
                else
                begin
                    i = node_total;
                    p = tail_node;
                    key_mem[i] = key;
                    rch_mem[i] = NO_NODE;
                    if (i == 0)
                    begin
                        par_mem[i] = NO_NODE;
                        lch_mem[i] = NO_NODE;
                        root_node = 0;
                    end
                    else if (key_mem[p] <= key)
                    begin
                        rch_mem[p] = i;
                        par_mem[i] = p;
                        lch_mem[i] = NO_NODE;
                    end
                    else
                    begin
                        // climb the right spine while the new key is strictly smaller
                        while (par_mem[p] != NO_NODE && par_mem[p] < i &&
                               key < key_mem[par_mem[p]])
                            p = par_mem[p];
                        par_mem[i] = par_mem[p];
                        if (par_mem[i] != NO_NODE && par_mem[i] < i)
                            rch_mem[par_mem[i]] = i;
                        else
                            root_node = i;
                        lch_mem[i] = p;
                        par_mem[p] = i;
                    end
                    tail_node = i;
                    node_total = i + 1;
                    r.par = ctb_pkg::LINK_OUT_W'(par_mem[i]);
                    r.lch = ctb_pkg::LINK_OUT_W'(lch_mem[i]);
                    r.rch = ctb_pkg::LINK_OUT_W'(rch_mem[i]);
                end
            end
            ctb_pkg::FUNC_QUERY:
            begin
                if (idx < node_total)
                begin
                    r.par = ctb_pkg::LINK_OUT_W'(par_mem[idx]);
                    r.lch = ctb_pkg::LINK_OUT_W'(lch_mem[idx]);
                    r.rch = ctb_pkg::LINK_OUT_W'(rch_mem[idx]);
                end
            end
            ctb_pkg::FUNC_CLEAR:
            begin
                node_total = 0;
                tail_node = 0;
                root_node = NO_NODE;
            end
            default:
            begin
            end
        endcase
        r.root = ctb_pkg::LINK_OUT_W'(root_node);
        r.cnt = ctb_pkg::LINK_OUT_W'(node_total);
        return r;
    endfunction

    // Runs of rising or falling keys build long spines and deep climbs; narrow keys
    // give many equal keys.
    function automatic logic signed [ctb_pkg::VALUE_W-1:0] next_key();
        if (key_run == 0)
        begin
            key_style = key_style_t'($urandom_range(0, 3));
            key_run = $urandom_range(2, 40);
        end
        key_run--;
        case (key_style)
            KEYS_NARROW:  last_key = $signed($urandom_range(0, 7)) - 3;
            KEYS_RISING:  last_key = last_key + $signed($urandom_range(0, 1000));
            KEYS_FALLING: last_key = last_key - $signed($urandom_range(0, 1000));
            default:      last_key = $urandom;
        endcase
        return last_key;
    endfunction

    // Pace the sender in bursts, then hold the item until it is taken.
    task automatic send_item(input logic [ctb_pkg::FUNC_W-1:0] op,
                             input logic [ctb_pkg::VALUE_W-1:0] key,
                             input logic [ctb_pkg::NODE_IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {{(ctb_pkg::S_TDATA_W - ctb_pkg::VALUE_W - ctb_pkg::NODE_IDX_W){1'b0}},
                         idx, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(tree_step(op, key, idx));
    endtask

    task automatic hold_until_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result(input tree_result_t got);
        tree_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h with nothing pending", got);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.par !== want.par || got.lch !== want.lch || got.rch !== want.rch ||
                got.root !== want.root || got.cnt !== want.cnt || got.ovf !== want.ovf)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp par=%0d lch=%0d rch=%0d root=%0d cnt=%0d ovf=%0b",
                             $signed(want.par), $signed(want.lch), $signed(want.rch),
                             $signed(want.root), want.cnt, want.ovf,
                             " got par=%0d lch=%0d rch=%0d root=%0d cnt=%0d ovf=%0b",
                             $signed(got.par), $signed(got.lch), $signed(got.rch),
                             $signed(got.root), got.cnt, got.ovf);
            end
        end
    endtask

    // Take results and drive the receiver's own stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(tree_result_t'(m_axis_tdata));
            if (stall_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 2));
                stall_left = $urandom_range(8, 60);
            end
            stall_left--;
            case (stall_mode)
                RX_FLOW:   m_axis_tready <= 1'b1;
                RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
                default:   m_axis_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(ctb_pkg::FUNC_QUERY, $urandom, 0);
        send_item(FUNC_SPARE, '1, '1);
        send_item(ctb_pkg::FUNC_APPEND, 32'sd5, '1);
        send_item(ctb_pkg::FUNC_APPEND, 32'h7FFF_FFFF, 0);
        send_item(ctb_pkg::FUNC_APPEND, 32'h7FFF_FFFF, 0);
        // equal to the root's key: stop below the earlier node
        send_item(ctb_pkg::FUNC_APPEND, 32'sd5, 0);
        // smallest key climbs the whole spine and takes the root
        send_item(ctb_pkg::FUNC_APPEND, 32'h8000_0000, 0);
        send_item(ctb_pkg::FUNC_APPEND, 32'sd0, 0);
        send_item(ctb_pkg::FUNC_APPEND, -32'sd1, 0);
        for (int n = 0; n < 7; n++)
            send_item(ctb_pkg::FUNC_QUERY, $urandom, ctb_pkg::NODE_IDX_W'(n));
        send_item(ctb_pkg::FUNC_QUERY, 0, 7);
        send_item(ctb_pkg::FUNC_QUERY, '1, '1);
        send_item(FUNC_SPARE, 0, 0);
        send_item(ctb_pkg::FUNC_CLEAR, $urandom, ctb_pkg::NODE_IDX_W'($urandom));
        send_item(ctb_pkg::FUNC_QUERY, 0, 0);
        send_item(ctb_pkg::FUNC_APPEND, -32'sd7, 0);
        send_item(ctb_pkg::FUNC_QUERY, 0, 0);
    endtask

    task automatic test_random_builds();
        int sent;
        int roll;
        logic [ctb_pkg::NODE_IDX_W-1:0] idx;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 199);
            if (roll == 0)
                send_item(ctb_pkg::FUNC_CLEAR, $urandom, ctb_pkg::NODE_IDX_W'($urandom));
            else if (roll == 1)
                send_item(FUNC_SPARE, $urandom, ctb_pkg::NODE_IDX_W'($urandom));
            else if (roll < 45)
            begin
                if (node_total == 0 || $urandom_range(0, 7) == 0)
                    idx = ctb_pkg::NODE_IDX_W'($urandom);
                else
                    idx = ctb_pkg::NODE_IDX_W'($urandom_range(0, node_total - 1));
                send_item(ctb_pkg::FUNC_QUERY, $urandom, idx);
            end
            else
                send_item(ctb_pkg::FUNC_APPEND, next_key(), ctb_pkg::NODE_IDX_W'($urandom));
            if (roll != 1)
                sent++;
        end
    endtask

    task automatic test_overflow();
        // let the pipeline empty out before filling the store
        hold_until_idle();
        send_item(ctb_pkg::FUNC_CLEAR, 0, 0);
        for (int n = 0; n < NODES; n++)
            send_item(ctb_pkg::FUNC_APPEND, next_key(), ctb_pkg::NODE_IDX_W'($urandom));
        send_item(ctb_pkg::FUNC_QUERY, 0, '1);
        send_item(ctb_pkg::FUNC_APPEND, 32'h8000_0000, 0);
        send_item(ctb_pkg::FUNC_APPEND, 32'h7FFF_FFFF, '1);
        send_item(ctb_pkg::FUNC_APPEND, $urandom, ctb_pkg::NODE_IDX_W'($urandom));
        send_item(ctb_pkg::FUNC_QUERY, $urandom, 0);
        send_item(FUNC_SPARE, $urandom, ctb_pkg::NODE_IDX_W'($urandom));
        send_item(ctb_pkg::FUNC_CLEAR, 0, 0);
        send_item(ctb_pkg::FUNC_QUERY, 0, 0);
    endtask

    initial
    begin
        node_total = 0;
        tail_node = 0;
        root_node = NO_NODE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_builds();
        test_overflow();
        hold_until_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
